// File: rtl/rcdc_pkg.sv
// Shared constants, register indexes and inter-module types of the RGB 3x3
// convolution filter. No dependencies.
package rcdc_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_COEF_BITS  = 12;

  // Kernel geometry and pixel range.
  localparam int KSIZE   = 3;
  localparam int TAPS    = KSIZE * KSIZE;
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int NLANES  = 3;

  // Fixed widths of the configuration and result fields.
  localparam int DIV_W  = 12;
  localparam int SIZE_W = 11;
  localparam int POS_W  = 10;

  // Configuration register indexes.
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_COEF_TOP    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COEF_MID    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEF_BOTTOM = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIVISOR     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_WIDTH       = 3'd4;
  localparam logic [CFG_AW-1:0] REG_HEIGHT      = 3'd5;

  // Status and result of one colour lane.
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] value;
  } lane_res_t;

  // Position and frame marker of the interior pixel in flight.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } pos_t;

endpackage

// File: rtl/rcdc_lane.sv
// One colour lane: serial multiply-accumulate over the nine window taps,
// then a shift-subtract divider and a clamp to 0..255. Uses rcdc_pkg.
module rcdc_lane #(
  parameter int COEF_BITS = rcdc_pkg::DEF_COEF_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start_i,
  input  logic [rcdc_pkg::TAPS-1:0][rcdc_pkg::PIX_W-1:0]    samp_i,
  input  logic [rcdc_pkg::TAPS-1:0][COEF_BITS-1:0]          coef_i,
  input  logic [rcdc_pkg::DIV_W-1:0]                        div_i,
  output rcdc_pkg::lane_res_t                               res_o
);
  import rcdc_pkg::*;

  localparam int PW    = PIX_W + 1 + COEF_BITS;
  localparam int SUM_W = PW + 4;
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam int KW    = $clog2(TAPS + 1);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MAC  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;

  logic [1:0]              state_r;
  logic [KW-1:0]           k_r;
  logic [DCW-1:0]          dcnt_r;
  logic                    done_r;
  logic [PIX_W-1:0]        value_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [SUM_W-1:0] acc_r;
  logic [DIV_W-1:0]        rem_r;
  logic [SUM_W-1:0]        quo_r;

  logic [KW-1:0]           sel;
  logic signed [PW-1:0]    product;
  logic signed [SUM_W-1:0] acc_sum;
  logic [DIV_W:0]          shifted;
  logic [DIV_W:0]          diff;
  logic                    ge;
  logic [SUM_W-1:0]        quo_nxt;

  // Product of the tap selected by the step counter.
  always_comb begin
    sel     = (k_r < KW'(TAPS)) ? k_r : '0;
    product = $signed({1'b0, samp_i[sel]}) * $signed(coef_i[sel]);
    acc_sum = acc_r + {{(SUM_W - PW){prod_r[PW-1]}}, prod_r};
  end

  // One quotient bit per cycle.
  always_comb begin
    shifted = {rem_r, quo_r[SUM_W-1]};
    diff    = shifted - {1'b0, div_i};
    ge      = (shifted >= {1'b0, div_i});
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start_i) begin
            done_r  <= 1'b0;
            state_r <= L_MAC;
          end
        end
        L_MAC: begin
          if (k_r == KW'(TAPS)) begin
            if (acc_sum <= 0) begin
              // A sum of zero or below always clamps to zero.
              value_r <= '0;
              done_r  <= 1'b1;
              state_r <= L_IDLE;
            end else begin
              state_r <= L_DIV;
            end
          end
        end
        L_DIV: begin
          if (dcnt_r == DCW'(1)) begin
            value_r <= (quo_nxt > SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : quo_nxt[PIX_W-1:0];
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        k_r   <= '0;
        acc_r <= '0;
      end
      L_MAC: begin
        if (k_r < KW'(TAPS)) begin
          prod_r <= product;
        end
        if (k_r != '0) begin
          acc_r <= acc_sum;
        end
        k_r    <= k_r + KW'(1);
        rem_r  <= '0;
        quo_r  <= acc_sum;
        dcnt_r <= DCW'(SUM_W);
      end
      L_DIV: begin
        rem_r  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_r  <= quo_nxt;
        dcnt_r <= dcnt_r - DCW'(1);
      end
      default: k_r <= '0;
    endcase
  end

  assign res_o.done  = done_r;
  assign res_o.value = value_r;

endmodule

// File: rtl/rcdc_merge.sv
// Merging stage: joins the three lane results and the pixel position into
// the output word register. Uses rcdc_pkg.
module rcdc_merge (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        load_i,
  input  logic [rcdc_pkg::NLANES-1:0][rcdc_pkg::PIX_W-1:0] value_i,
  input  rcdc_pkg::pos_t                              pos_i,
  output logic                                        ready_o,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [47:0]                                 out_tdata,
  output logic                                        out_tlast
);
  import rcdc_pkg::*;

  logic        valid_r;
  logic [47:0] data_r;
  logic        last_r;

  assign ready_o = !valid_r || out_tready;

  // Valid flag of the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Output word: red, green, blue, row, column from bit 0 up.
  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= {4'b0, pos_i.col, pos_i.row, value_i[2], value_i[1], value_i[0]};
      last_r <= pos_i.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// File: rtl/rgb_convolution_3x3_divide_clamp.sv
// Top level of the RGB 3x3 convolution filter: configuration registers,
// line stores, window, position counters and control. Uses rcdc_pkg,
// rcdc_lane and rcdc_merge.
//
//  Port group   Direction  Word contents
//  in_*         slave      tdata: red[7:0], green[15:8], blue[23:16]
//  out_*        master     tdata: red, green, blue, row, column; tlast: frame end
//  cfg_*        write      index 0..5: coefficient rows, divisor, width, height
//
// A border pixel passes through acceptance and the window update. An interior
// pixel adds a lane start and a result load around the lanes' ten-step
// multiply-accumulate and one-bit-a-cycle divider. A sum of zero or below
// skips the divider.
// Reset is synchronous and active low; it clears control, window and counters.
// A stalled result waits in the output register; the next pixel is taken
// meanwhile, and its result waits in the lanes until the register frees.
module rgb_convolution_3x3_divide_clamp #(
  parameter int MAX_WIDTH  = rcdc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rcdc_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_BITS  = rcdc_pkg::DEF_COEF_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // red, green, blue
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,  // red, green, blue, row, col, zeros
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [rcdc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [3*COEF_BITS-1:0]        cfg_wdata
);
  import rcdc_pkg::*;

  localparam int CW3 = 3 * COEF_BITS;
  localparam int CCW = $clog2(MAX_WIDTH);
  localparam int RCW = $clog2(MAX_HEIGHT);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int MB  = (WB > HB) ? WB : HB;
  localparam int SZW = (MB > SIZE_W) ? MB + 1 : SIZE_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;

  // Configuration registers.
  logic [CW3-1:0]    coef_top_r, coef_mid_r, coef_bot_r;
  logic [DIV_W-1:0]  div_r;
  logic [SIZE_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= '0;
      coef_mid_r <= CW3'(1) << COEF_BITS;
      coef_bot_r <= '0;
      div_r      <= DIV_W'(1);
      width_r    <= SIZE_W'(1024);
      height_r   <= SIZE_W'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_TOP:    coef_top_r <= cfg_wdata;
        REG_COEF_MID:    coef_mid_r <= cfg_wdata;
        REG_COEF_BOTTOM: coef_bot_r <= cfg_wdata;
        REG_DIVISOR:     div_r      <= cfg_wdata[DIV_W-1:0];
        REG_WIDTH:       width_r    <= cfg_wdata[SIZE_W-1:0];
        REG_HEIGHT:      height_r   <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [1:0]         state_r;
  logic [CCW-1:0]     col_r;
  logic [RCW-1:0]     row_r;
  logic [23:0]        pix_r, up_rd_r, lo_rd_r;
  logic [CCW-1:0]     addr_r;
  logic               interior_r;
  logic               start_r;
  pos_t               pos_r;
  logic [TAPS-1:0][23:0] win_r;
  logic [23:0]        upper_mem [MAX_WIDTH];
  logic [23:0]        lower_mem [MAX_WIDTH];

  logic               accept;
  logic [SZW-1:0]     wid_x, hgt_x, ew, eh;
  logic [SZW-1:0]     c_x, r_x, c_e, r_t, r_e, c_n, r_n1;
  logic [SZW-1:0]     col_nxt, row_nxt;
  logic [DIV_W-1:0]   div_eff;
  logic               all_done, merge_rdy, load;
  lane_res_t          lane_res [NLANES];
  logic [NLANES-1:0]  lane_done;
  logic [NLANES-1:0][PIX_W-1:0] lane_val;
  logic [NLANES-1:0][TAPS-1:0][PIX_W-1:0] samp;
  logic [TAPS-1:0][COEF_BITS-1:0] coef_all;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign div_eff   = (div_r == '0) ? DIV_W'(1) : div_r;

  // Effective frame size and position of the incoming pixel.
  always_comb begin
    wid_x = SZW'(width_r);
    hgt_x = SZW'(height_r);
    ew = (wid_x < SZW'(KSIZE)) ? SZW'(KSIZE) :
         (wid_x > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : wid_x;
    eh = (hgt_x < SZW'(KSIZE)) ? SZW'(KSIZE) :
         (hgt_x > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : hgt_x;
    c_x = SZW'(col_r);
    r_x = SZW'(row_r);
    c_e = (c_x >= ew) ? '0 : c_x;
    r_t = (c_x >= ew) ? r_x + SZW'(1) : r_x;
    r_e = (r_t >= eh) ? '0 : r_t;
    c_n = c_e + SZW'(1);
    col_nxt = (c_n >= ew) ? '0 : c_n;
    r_n1    = (c_n >= ew) ? r_e + SZW'(1) : r_e;
    row_nxt = (r_n1 >= eh) ? '0 : r_n1;
  end

  // Control state and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= (state_r == S_SHIFT) && interior_r;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            col_r   <= col_nxt[CCW-1:0];
            row_r   <= row_nxt[RCW-1:0];
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: state_r <= interior_r ? S_CALC : S_IDLE;
        S_CALC: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Word captured on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r      <= in_tdata;
      addr_r     <= c_e[CCW-1:0];
      interior_r <= (r_e >= SZW'(2)) && (c_e >= SZW'(2));
      pos_r.row  <= POS_W'(r_e - SZW'(1));
      pos_r.col  <= POS_W'(c_e - SZW'(1));
      pos_r.last <= (r_e == eh - SZW'(1)) && (c_e == ew - SZW'(1));
    end
  end

  // Line stores: read on acceptance, written back in the next cycle, the window update.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r <= upper_mem[c_e[CCW-1:0]];
      lo_rd_r <= lower_mem[c_e[CCW-1:0]];
    end
    if (state_r == S_SHIFT) begin
      upper_mem[addr_r] <= lo_rd_r;
      lower_mem[addr_r] <= pix_r;
    end
  end

  // 3x3 window, each row shifting left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (state_r == S_SHIFT) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= up_rd_r;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= lo_rd_r;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pix_r;
    end
  end

  // Lane operands: one colour plane each, coefficients shared.
  always_comb begin
    for (int p = 0; p < NLANES; p++) begin
      for (int k = 0; k < TAPS; k++) begin
        samp[p][k] = win_r[k][p*PIX_W +: PIX_W];
      end
    end
    for (int j = 0; j < KSIZE; j++) begin
      coef_all[j]           = coef_top_r[j*COEF_BITS +: COEF_BITS];
      coef_all[KSIZE + j]   = coef_mid_r[j*COEF_BITS +: COEF_BITS];
      coef_all[2*KSIZE + j] = coef_bot_r[j*COEF_BITS +: COEF_BITS];
    end
  end

  for (genvar p = 0; p < NLANES; p++) begin : g_lane
    rcdc_lane #(
      .COEF_BITS (COEF_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start_i (start_r),
      .samp_i  (samp[p]),
      .coef_i  (coef_all),
      .div_i   (div_eff),
      .res_o   (lane_res[p])
    );
    assign lane_done[p] = lane_res[p].done;
    assign lane_val[p]  = lane_res[p].value;
  end

  assign all_done = &lane_done;
  assign load     = (state_r == S_CALC) && !start_r && all_done && merge_rdy;

  rcdc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .value_i    (lane_val),
    .pos_i      (pos_r),
    .ready_o    (merge_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // An accepted word is always followed by the window update.
  a_accept_shift: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SHIFT)
    else $error("accepted word not followed by window update");

  // The lanes are started only for a word already in the calculation state.
  a_start_calc: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == S_CALC)
    else $error("lane start outside calculation");

  // A result is loaded only when all three lanes agree they are done.
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> lane_done == {NLANES{1'b1}})
    else $error("result loaded before all lanes finished");

  // A new result appears only after a calculation.
  a_out_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_CALC))
    else $error("result appeared without a calculation");

endmodule
